### hdl/dwtq_pkg.sv
// Package: shared constants, codes, state and control types for the timer queue.
`default_nettype none
package dwtq_pkg;
  localparam int QUEUE_DEPTH  = 32;
  localparam int TASK_ID_BITS = 16;

  localparam logic [1:0] ST_NOTIFY = 2'd0;
  localparam logic [1:0] ST_WOKEN  = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_REL_RD,
    S_REL_CMP,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic latch;
    logic rd_ins;
    logic rd_head;
    logic wr_shift;
    logic wr_new;
    logic pop;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic req_store;
    logic pos_zero;
    logic ins_gt;
    logic empty;
    logic rel_ok;
  } stat_t;
endpackage
`default_nettype wire

### hdl/delay_wakeup_timer_queue.sv
// Top level: sleep/wake timer queue, controller plus datapath.
// An item keeps busy high from acceptance until its steps are done: entries shifted on
// insert, then entries woken, one read-compare round trip of the entry memory per step,
// then a flush. Results come each for one cycle on strobe, the last one in the first
// cycle that busy is low; the receiver cannot stall.
// Synchronous reset empties the queue; memory contents are left undefined.
`default_nettype none
module delay_wakeup_timer_queue #(
  parameter int QUEUE_DEPTH  = dwtq_pkg::QUEUE_DEPTH,
  parameter int TASK_ID_BITS = dwtq_pkg::TASK_ID_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [15:0] task_id,
  input  wire logic [31:0] delay_ms,
  input  wire logic [31:0] now_ms,
  output logic             strobe,
  output logic [1:0]       status,
  output logic [15:0]      reply_task,
  output logic             last
);
  dwtq_pkg::cmd_t  cmd;
  dwtq_pkg::stat_t st;

  dwtq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  dwtq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_type   (req_type),
    .task_id    (task_id),
    .delay_ms   (delay_ms),
    .now_ms     (now_ms),
    .cmd        (cmd),
    .st         (st),
    .strobe     (strobe),
    .status     (status),
    .reply_task (reply_task),
    .last       (last)
  );
endmodule
`default_nettype wire

### hdl/dwtq_ctrl.sv
// Controller: sequences insertion and release steps for one item.
`default_nettype none
module dwtq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire dwtq_pkg::stat_t st,
  output dwtq_pkg::cmd_t       cmd
);
  dwtq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= dwtq_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != dwtq_pkg::S_IDLE);
    case (state)
      dwtq_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = st.req_store ? dwtq_pkg::S_INS_RD : dwtq_pkg::S_REL_RD;
        end
      end
      dwtq_pkg::S_INS_RD: begin
        if (st.pos_zero) begin
          cmd.wr_new = 1'b1;
          state_next = dwtq_pkg::S_REL_RD;
        end else begin
          cmd.rd_ins = 1'b1;
          state_next = dwtq_pkg::S_INS_CMP;
        end
      end
      dwtq_pkg::S_INS_CMP: begin
        if (st.ins_gt) begin
          cmd.wr_shift = 1'b1;
          state_next   = dwtq_pkg::S_INS_RD;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = dwtq_pkg::S_REL_RD;
        end
      end
      dwtq_pkg::S_REL_RD: begin
        if (st.empty) begin
          state_next = dwtq_pkg::S_FLUSH;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = dwtq_pkg::S_REL_CMP;
        end
      end
      dwtq_pkg::S_REL_CMP: begin
        if (st.rel_ok) begin
          cmd.pop    = 1'b1;
          state_next = dwtq_pkg::S_REL_RD;
        end else begin
          state_next = dwtq_pkg::S_FLUSH;
        end
      end
      dwtq_pkg::S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = dwtq_pkg::S_IDLE;
      end
      default: state_next = dwtq_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hdl/dwtq_dp.sv
// Datapath: sorted circular entry memory, request registers and result register.
`default_nettype none
module dwtq_dp #(
  parameter int QUEUE_DEPTH  = dwtq_pkg::QUEUE_DEPTH,
  parameter int TASK_ID_BITS = dwtq_pkg::TASK_ID_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_type,
  input  wire logic [15:0] task_id,
  input  wire logic [31:0] delay_ms,
  input  wire logic [31:0] now_ms,
  input  wire dwtq_pkg::cmd_t cmd,
  output dwtq_pkg::stat_t     st,
  output logic             strobe,
  output logic [1:0]       status,
  output logic [15:0]      reply_task,
  output logic             last
);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TB = TASK_ID_BITS;
  localparam int EW = 32 + TB;

  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rdata;
  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [TB-1:0] q_task;
  logic [31:0]   q_wake;
  logic [31:0]   q_now;
  logic [1:0]    pend_status;
  logic [TB-1:0] pend_task;
  logic          have_pend;
  logic [TB-1:0] in_task;
  logic [15:0]   out_task;
  logic [CW-1:0] pos_m1;
  logic [PW-1:0] addr_pos, addr_pm1;
  logic [PW:0]   sum_pos, sum_pm1;

  always_comb begin
    for (int i = 0; i < TB; i++) in_task[i] = (i < 16) ? task_id[i] : 1'b0;
    for (int i = 0; i < 16; i++) out_task[i] = (i < TB) ? pend_task[i] : 1'b0;
  end

  assign pos_m1  = pos - CW'(1);
  assign sum_pos = {1'b0, head} + (PW+1)'(pos);
  assign sum_pm1 = {1'b0, head} + (PW+1)'(pos_m1);
  assign addr_pos = (sum_pos >= (PW+1)'(QUEUE_DEPTH)) ?
                    PW'(sum_pos - (PW+1)'(QUEUE_DEPTH)) : PW'(sum_pos);
  assign addr_pm1 = (sum_pm1 >= (PW+1)'(QUEUE_DEPTH)) ?
                    PW'(sum_pm1 - (PW+1)'(QUEUE_DEPTH)) : PW'(sum_pm1);

  assign st.req_store = req_type && (count != CW'(QUEUE_DEPTH));
  assign st.pos_zero  = (pos == '0);
  assign st.ins_gt    = rdata[EW-1:TB] > q_wake;
  assign st.empty     = (count == '0);
  assign st.rel_ok    = rdata[EW-1:TB] <= q_now;

  always_ff @(posedge clk) begin
    if (cmd.wr_shift) mem[addr_pos] <= rdata;
    else if (cmd.wr_new) mem[addr_pos] <= {q_wake, q_task};
    if (cmd.rd_ins) rdata <= mem[addr_pm1];
    else if (cmd.rd_head) rdata <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      q_task <= in_task;
      q_wake <= now_ms + delay_ms;
      q_now  <= now_ms;
      pos    <= count;
    end else if (cmd.wr_shift) begin
      pos <= pos_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      have_pend <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.latch) begin
        have_pend   <= !(req_type && (count != CW'(QUEUE_DEPTH)));
        pend_status <= req_type ? dwtq_pkg::ST_DROP : dwtq_pkg::ST_NOTIFY;
        pend_task   <= in_task;
      end
      if (cmd.wr_new) count <= count + CW'(1);
      if (cmd.pop) begin
        head        <= (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
        count       <= count - CW'(1);
        strobe      <= have_pend;
        status      <= pend_status;
        reply_task  <= out_task;
        last        <= 1'b0;
        have_pend   <= 1'b1;
        pend_status <= dwtq_pkg::ST_WOKEN;
        pend_task   <= rdata[TB-1:0];
      end
      if (cmd.flush) begin
        strobe     <= have_pend;
        status     <= pend_status;
        reply_task <= out_task;
        last       <= 1'b1;
        have_pend  <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("entry count out of range");
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head < PW'(QUEUE_DEPTH) || QUEUE_DEPTH == (1 << PW)) else $error("head out of range");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - CW'(1)) else $error("pop did not drop count");
  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !have_pend) else $error("pending result kept after flush");
endmodule
`default_nettype wire

### tb/delay_wakeup_timer_queue_tb.sv
// Testbench: directed table then random requests against a queue predictor, with idle gaps.
`default_nettype none
module delay_wakeup_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_NOTIFY = 1'b0;
  localparam logic REQ_DELAY  = 1'b1;

  typedef struct {
    logic        kind;
    logic [15:0] task_no;
    logic [31:0] delay;
    logic [31:0] now;
    logic        fixed;
    logic [1:0]  fix_status;
    logic [15:0] fix_task;
  } row_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] reply_task;
    logic        last;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic req_type = 1'b0;
  logic [15:0] task_id = '0;
  logic [31:0] delay_ms = '0;
  logic [31:0] now_ms = '0;
  logic busy, strobe, last;
  logic [1:0] status;
  logic [15:0] reply_task;

  logic [31:0] sleep_wake[$];
  logic [15:0] sleep_task[$];
  reply_t      due_replies[$];
  int          errors = 0;
  row_t        rows[$];

  delay_wakeup_timer_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .task_id(task_id), .delay_ms(delay_ms), .now_ms(now_ms),
    .strobe(strobe), .status(status), .reply_task(reply_task), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("delay_wakeup_timer_queue_tb: FAIL");
    $finish;
  end

  function automatic void predict_wakeups(logic kind, logic [15:0] tk, logic [31:0] dly,
                                         logic [31:0] now);
    reply_t r;
    int     pos;
    int     first;
    first = due_replies.size();
    if (kind == REQ_NOTIFY) begin
      r = '{dwtq_pkg::ST_NOTIFY, tk, 1'b0};
      due_replies.push_back(r);
    end else if (sleep_wake.size() >= dwtq_pkg::QUEUE_DEPTH) begin
      r = '{dwtq_pkg::ST_DROP, tk, 1'b0};
      due_replies.push_back(r);
    end else begin
      pos = sleep_wake.size();
      while (pos > 0 && sleep_wake[pos-1] > now + dly) pos--;
      sleep_wake.insert(pos, now + dly);
      sleep_task.insert(pos, tk);
    end
    while (sleep_wake.size() > 0 && sleep_wake[0] <= now) begin
      r = '{dwtq_pkg::ST_WOKEN, sleep_task[0], 1'b0};
      due_replies.push_back(r);
      void'(sleep_wake.pop_front());
      void'(sleep_task.pop_front());
    end
    if (due_replies.size() > first) due_replies[due_replies.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    reply_t e;
    if (!rst && strobe) begin
      if (due_replies.size() == 0) begin
        $error("unexpected result status=%0d reply_task=%0h", status, reply_task);
        errors++;
      end else begin
        e = due_replies.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status); errors++;
        end
        if (reply_task !== e.reply_task) begin
          $error("reply_task expected %0h actual %0h", e.reply_task, reply_task); errors++;
        end
        if (last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, last); errors++;
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    repeat (n) @(negedge clk);
  endtask

  task automatic send(row_t rw);
    reply_t r;
    while (busy) @(negedge clk);
    if (rw.fixed && rw.kind == REQ_NOTIFY && sleep_wake.size() == 0) begin
      r = '{rw.fix_status, rw.fix_task, 1'b1};
      due_replies.push_back(r);
    end else predict_wakeups(rw.kind, rw.task_no, rw.delay, rw.now);
    req_type <= rw.kind;
    task_id  <= rw.task_no;
    delay_ms <= rw.delay;
    now_ms   <= rw.now;
    start    <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic row_t mk(logic k, logic [15:0] t, logic [31:0] d, logic [31:0] n);
    row_t rw;
    rw = '{k, t, d, n, 1'b0, dwtq_pkg::ST_NOTIFY, 16'h0};
    return rw;
  endfunction

  initial begin
    row_t        rw;
    logic [31:0] clock_ms;
    int          waited;
    rows.push_back('{REQ_NOTIFY, 16'h0000, 32'h0, 32'h0, 1'b1, dwtq_pkg::ST_NOTIFY,
                     16'h0000});
    rows.push_back('{REQ_NOTIFY, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     dwtq_pkg::ST_NOTIFY, 16'hFFFF});
    rows.push_back(mk(REQ_DELAY, 16'h1234, 32'h0, 32'h100));
    rows.push_back(mk(REQ_DELAY, 16'h0001, 32'h50, 32'h100));
    rows.push_back(mk(REQ_DELAY, 16'h0002, 32'h50, 32'h100));
    rows.push_back(mk(REQ_DELAY, 16'h0003, 32'h20, 32'h110));
    rows.push_back(mk(REQ_NOTIFY, 16'hAAAA, 32'h0, 32'h150));
    rows.push_back(mk(REQ_DELAY, 16'h5555, 32'hFFFF_FFF0, 32'h200));
    rows.push_back(mk(REQ_DELAY, 16'hFFFF, 32'hFFFF_FFFF, 32'h0));
    rows.push_back(mk(REQ_DELAY, 16'h0000, 32'h0, 32'hFFFF_FFFF));
    for (int i = 0; i < dwtq_pkg::QUEUE_DEPTH + 2; i++)
      rows.push_back(mk(REQ_DELAY, 16'(16'hC000 + i), 32'(1000 + (i % 5)), 32'h300));
    rows.push_back(mk(REQ_NOTIFY, 16'h7777, 32'h0, 32'hFFFF_FFFF));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (rows[i]) send(rows[i]);
    clock_ms = 32'd1000;
    for (int i = 0; i < 236; i++) begin
      idle_gap();
      if (i == 120) begin
        waited = 0;
        while (due_replies.size() != 0 && waited < 2000) begin
          @(negedge clk); waited++;
        end
      end
      clock_ms = clock_ms + $urandom_range(0, 40);
      rw = mk(($urandom_range(0, 3) != 0) ? REQ_DELAY : REQ_NOTIFY, 16'($urandom),
              32'($urandom_range(0, 120)), clock_ms);
      case ($urandom_range(0, 15))
        0: rw.delay = $urandom;
        1: rw.now = $urandom;
        2: rw.delay = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: ;
      endcase
      send(rw);
    end
    waited = 0;
    while (due_replies.size() != 0 && waited < 5000) begin
      @(negedge clk); waited++;
    end
    repeat (200) @(negedge clk);
    if (errors == 0 && due_replies.size() == 0) begin
      $display("delay_wakeup_timer_queue_tb: PASS");
    end else begin
      $display("delay_wakeup_timer_queue_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
